FILE: rtl/sbc3_pkg.sv
// ----------------------------------------------------------------------------
// sbc3_pkg: shared types and constants for the 3D segment/box clipper
// Register indexes, field widths, channel payloads and the per-axis test codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc3_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned ADDR_W = 5;

	// register indexes
	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// input transaction: one segment
	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
	} seg_t;

	// output transaction: hit flag and clipped endpoints
	typedef struct packed {
		logic   hit;
		coord_t clip_start_x;
		coord_t clip_start_y;
		coord_t clip_start_z;
		coord_t clip_end_x;
		coord_t clip_end_y;
		coord_t clip_end_z;
	} clip_t;

	// what one face test does to a parameter
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_DIV   = 2'd1,
		ACT_FORCE = 2'd2
	} act_t;

endpackage : sbc3_pkg

`default_nettype wire

FILE: rtl/sbc3_if.sv
// ----------------------------------------------------------------------------
// sbc3_if: valid/ready channel carrying one payload
// Used for the segment input and the clipped result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc3_if #(
	parameter type payload_t = logic
) (
	input wire logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : sbc3_if

`default_nettype wire

FILE: rtl/sbc3_div_cell.sv
// ----------------------------------------------------------------------------
// sbc3_div_cell: one restoring-division step of the divider chain
// Each cell takes one quotient bit of every lane and hands the partial
// remainders plus the carried segment data to its neighbor each enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc3_div_cell #(
	parameter int unsigned DEN_W = 33,
	parameter int unsigned Q_W = 17,
	parameter int unsigned LANES = 6,
	parameter int unsigned SIDE_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vld_in,
	input  wire logic [LANES-1:0][DEN_W:0]   rem_in,
	input  wire logic [LANES-1:0][DEN_W-1:0] den_in,
	input  wire logic [LANES-1:0][Q_W-1:0]   quo_in,
	input  wire logic [SIDE_W-1:0]     side_in,
	output logic                       vld_out,
	output logic [LANES-1:0][DEN_W:0]   rem_out,
	output logic [LANES-1:0][DEN_W-1:0] den_out,
	output logic [LANES-1:0][Q_W-1:0]   quo_out,
	output logic [SIDE_W-1:0]          side_out
);

	logic [LANES-1:0][DEN_W:0] rem_nx;
	logic [LANES-1:0][Q_W-1:0] quo_nx;

	// shift, trial subtract, restore
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [DEN_W+1:0] sh;
			logic [DEN_W+1:0] df;
			sh = {rem_in[l], 1'b0};
			df = sh - {2'b00, den_in[l]};
			if (!df[DEN_W+1]) begin
				rem_nx[l] = df[DEN_W:0];
				quo_nx[l] = {quo_in[l][Q_W-2:0], 1'b1};
			end else begin
				rem_nx[l] = sh[DEN_W:0];
				quo_nx[l] = {quo_in[l][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= rem_nx;
			den_out  <= den_in;
			quo_out  <= quo_nx;
			side_out <= side_in;
		end
	end

endmodule : sbc3_div_cell

`default_nettype wire

FILE: rtl/sbc3_lerp_lane.sv
// ----------------------------------------------------------------------------
// sbc3_lerp_lane: interpolation of one clipped coordinate
// Registers |d|*t, then rounds and applies the sign of d.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc3_lerp_lane #(
	parameter int unsigned PF = 16
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [31:0]    a,
	input  wire logic signed [31:0]    b,
	input  wire logic [PF:0]           t,
	output logic signed [31:0]         res
);

	logic signed [32:0] d;
	logic [32:0]        dm;
	logic [PF+33:0]     prod_s1;
	logic               neg_s1;
	logic signed [31:0] a_s1;
	logic [31:0]        r;

	assign d  = 33'(signed'(b)) - 33'(signed'(a));
	assign dm = d[32] ? 33'(-d) : d;

	// stage 1: magnitude product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (PF+34)'(dm) * (PF+34)'(t);
			neg_s1  <= d[32];
			a_s1    <= a;
		end
	end

	// stage 2: round half away, reapply sign
	always_comb begin
		logic [PF+33:0] s;
		s = prod_s1 + ((PF+34)'(1) << (PF-1));
		r = s[PF+31:PF];
	end
	assign res = neg_s1 ? a_s1 - signed'(r) : a_s1 + signed'(r);

endmodule : sbc3_lerp_lane

`default_nettype wire

FILE: rtl/segment_box_clip_3d_core.sv
// ----------------------------------------------------------------------------
// segment_box_clip_3d_core: clips a 3D segment to a configured box
// Input skid, face tests, a chain of divider cells, min/max, lerp, output register.
//
//   channel | dir | payload
//   in_ch   | in  | start_x/y/z, end_x/y/z (signed Q16.16)
//   out_ch  | out | hit, clip_start_x/y/z, clip_end_x/y/z
//   apb     | in  | box_min_x..box_max_z at 4*i
//
// One transaction per cycle unless the pipe stalls; the divider chain yields
// one quotient bit per cell. Reset clears valid bits
// and box registers. The whole pipe stalls when the output register is
// full and not taken; input is still taken while the skid slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_clip_3d_core #(
	parameter int unsigned PARAM_FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sbc3_if.sink             in_ch,
	sbc3_if.source           out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [sbc3_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned PF = PARAM_FRACTION_BITS;
	localparam int unsigned QW = PF + 1;
	// doubled 33-bit magnitude
	localparam int unsigned DW = 34;
	localparam int unsigned NC = QW;
	localparam int unsigned LN = 6;
	// side: coords 192, actions 6x2
	localparam int unsigned SW = 192 + 12;

	// box registers
	logic [5:0][31:0] box_q;
	logic [2:0]       widx;
	assign widx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (psel && penable && pwrite && paddr[4:2] < 3'(sbc3_pkg::NUM_REGS)) begin
			box_q[widx] <= pwdata;
		end
	end
	always_comb begin
		prdata = '0;
		if (widx < 3'(sbc3_pkg::NUM_REGS)) prdata = box_q[widx];
	end

	// pipeline enable: move unless output holds data not taken
	logic out_vld_q, en;
	logic skid_vld_q;
	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = !skid_vld_q;

	// skid slot at the input
	sbc3_pkg::seg_t   skid_q, seg_cur;
	logic [5:0][31:0] cur;
	logic             cur_vld;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_ch.valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (!en && in_ch.valid && !skid_vld_q) skid_q <= in_ch.data;
	end
	assign cur_vld = skid_vld_q || in_ch.valid;
	assign seg_cur = skid_vld_q ? skid_q : in_ch.data;
	// word k: start coordinate of axis k, word 3+k: end coordinate
	assign cur = {seg_cur.end_z, seg_cur.end_y, seg_cur.end_x,
		seg_cur.start_z, seg_cur.start_y, seg_cur.start_x};

	// face tests: lanes 0..2 entry per axis, 3..5 exit per axis
	logic [LN-1:0][DW:0]   rem0;
	logic [LN-1:0][DW-1:0] den0;
	logic [LN-1:0][1:0]    act0;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [32:0] a, b, lo, hi, num0, num1, dd;
			logic [32:0]        dmag;
			a  = 33'(signed'(cur[k]));
			b  = 33'(signed'(cur[3+k]));
			lo = 33'(signed'(box_q[k]));
			hi = 33'(signed'(box_q[3+k]));
			dd = b - a;
			num0 = '0;
			num1 = '0;
			act0[k] = sbc3_pkg::ACT_NONE;
			act0[3+k] = sbc3_pkg::ACT_NONE;
			if (a < lo) begin
				num0 = lo - a;
				act0[k] = (b >= lo) ? sbc3_pkg::ACT_DIV : sbc3_pkg::ACT_FORCE;
			end else if (a > hi) begin
				num0 = hi - a;
				act0[k] = (b <= hi) ? sbc3_pkg::ACT_DIV : sbc3_pkg::ACT_FORCE;
			end
			if (b < lo) begin
				num1 = lo - a;
				act0[3+k] = (a >= lo) ? sbc3_pkg::ACT_DIV : sbc3_pkg::ACT_FORCE;
			end else if (b > hi) begin
				num1 = hi - a;
				act0[3+k] = (a <= hi) ? sbc3_pkg::ACT_DIV : sbc3_pkg::ACT_FORCE;
			end
			// |num| <= |den| on the divide paths, so remainder starts at |num|;
			// the divisor is doubled so the first cell yields the 1.0 bit
			rem0[k]   = {2'b00, num0[32] ? 33'(-num0) : num0};
			rem0[3+k] = {2'b00, num1[32] ? 33'(-num1) : num1};
			dmag      = dd[32] ? 33'(-dd) : dd;
			den0[k]   = {dmag, 1'b0};
			den0[3+k] = {dmag, 1'b0};
		end
	end

	// register the test results, then the divider chain
	logic [NC:0]                  vld_c;
	logic [NC:0][LN-1:0][DW:0]    rem_c;
	logic [NC:0][LN-1:0][DW-1:0]  den_c;
	logic [NC:0][LN-1:0][QW-1:0]  quo_c;
	logic [NC:0][SW-1:0]          side_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_c[0] <= 1'b0;
		else if (en) vld_c[0] <= cur_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_c[0]  <= rem0;
			den_c[0]  <= den0;
			quo_c[0]  <= '0;
			side_c[0] <= {act0, cur};
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_cell
		sbc3_div_cell #(.DEN_W(DW), .Q_W(QW), .LANES(LN), .SIDE_W(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[c]), .rem_in(rem_c[c]), .den_in(den_c[c]),
			.quo_in(quo_c[c]), .side_in(side_c[c]),
			.vld_out(vld_c[c+1]), .rem_out(rem_c[c+1]), .den_out(den_c[c+1]),
			.quo_out(quo_c[c+1]), .side_out(side_c[c+1])
		);
	end

	// combine parameters; first quotient bit weighs 1.0
	logic [5:0][31:0] pts;
	logic [LN-1:0][1:0] act;
	assign pts = side_c[NC][191:0];
	assign act = side_c[NC][SW-1:192];

	logic [QW-1:0] t0_s, t1_s;
	always_comb begin
		t0_s = '0;
		t1_s = QW'(1) << PF;
		for (int k = 0; k < 3; k++) begin
			logic [QW-1:0] q0, q1;
			q0 = (den_c[NC][k] == '0) ? (QW'(1) << PF) : quo_c[NC][k];
			q1 = (den_c[NC][3+k] == '0) ? (QW'(1) << PF) : quo_c[NC][3+k];
			if (q0 > (QW'(1) << PF)) q0 = QW'(1) << PF;
			if (q1 > (QW'(1) << PF)) q1 = QW'(1) << PF;
			case (act[k])
				sbc3_pkg::ACT_DIV:   if (q0 > t0_s) t0_s = q0;
				sbc3_pkg::ACT_FORCE: t0_s = QW'(1) << PF;
				default: ;
			endcase
			case (act[3+k])
				sbc3_pkg::ACT_DIV:   if (q1 < t1_s) t1_s = q1;
				sbc3_pkg::ACT_FORCE: t1_s = '0;
				default: ;
			endcase
		end
	end

	// register t0/t1 and points
	logic             vld_s1, vld_s2;
	logic [QW-1:0]    t0_s1, t1_s1;
	logic [5:0][31:0] pts_s1, pts_s2;
	logic             hit_s1, hit_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_c[NC];
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1  <= t0_s;
			t1_s1  <= t1_s;
			pts_s1 <= pts;
			hit_s1 <= !(t0_s > t1_s);
			pts_s2 <= pts_s1;
			hit_s2 <= hit_s1;
		end
	end

	// lerp lanes (product registered inside)
	logic [5:0][31:0] lr;
	for (genvar k = 0; k < 3; k++) begin : g_lerp
		sbc3_lerp_lane #(.PF(PF)) u_l0 (.clk(clk), .en(en), .a(pts_s1[k]),
			.b(pts_s1[3+k]), .t(t0_s1), .res(lr[k]));
		sbc3_lerp_lane #(.PF(PF)) u_l1 (.clk(clk), .en(en), .a(pts_s1[k]),
			.b(pts_s1[3+k]), .t(t1_s1), .res(lr[3+k]));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.hit          <= hit_s2;
			out_ch.data.clip_start_x <= hit_s2 ? lr[0] : pts_s2[0];
			out_ch.data.clip_start_y <= hit_s2 ? lr[1] : pts_s2[1];
			out_ch.data.clip_start_z <= hit_s2 ? lr[2] : pts_s2[2];
			out_ch.data.clip_end_x   <= hit_s2 ? lr[3] : pts_s2[3];
			out_ch.data.clip_end_y   <= hit_s2 ? lr[4] : pts_s2[4];
			out_ch.data.clip_end_z   <= hit_s2 ? lr[5] : pts_s2[5];
		end
	end
	assign out_ch.valid = out_vld_q;

endmodule : segment_box_clip_3d_core

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for segment_box_clip_3d_core
// Programs the clip box over the register port, streams segments through the
// input channel with random gaps and output stalls, and checks every clipped
// result against a bit-exact slab-clipping predictor held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int unsigned PFB = 16;
	localparam longint unsigned T_ONE = 64'd1 << PFB;
	localparam int DRAIN_CYCLES = PFB + 15;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [sbc3_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sbc3_if #(.payload_t(sbc3_pkg::seg_t))  seg_ch  (clk);
	sbc3_if #(.payload_t(sbc3_pkg::clip_t)) clip_ch (clk);

	segment_box_clip_3d_core #(.PARAM_FRACTION_BITS(PFB)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (seg_ch),
		.out_ch  (clip_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// box copy used by the predictor
	longint box_lo [3];
	longint box_hi [3];

	sbc3_pkg::clip_t clip_expect [$];
	int    errors;
	bit    steady;
	int    stall_left;
	int    quiet_cycles;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// |num|/|den| as unsigned Q1.PFB, truncated, capped at 1.0
	function automatic longint unsigned face_ratio(longint num, longint den);
		longint unsigned un, ud, q;
		un = mag(num);
		ud = mag(den);
		if (ud == 0)
			return T_ONE;
		q = (un << PFB) / ud;
		return (q > T_ONE) ? T_ONE : q;
	endfunction

	// a + t*(b-a), rounded to nearest on the magnitude
	function automatic sbc3_pkg::coord_t interp(longint a, longint b, longint unsigned t);
		longint d;
		longint unsigned m, r;
		d = b - a;
		m = mag(d) * t;
		r = (m + (T_ONE >> 1)) >> PFB;
		return (d < 0) ? sbc3_pkg::coord_t'(a - longint'(r))
			: sbc3_pkg::coord_t'(a + longint'(r));
	endfunction

	function automatic sbc3_pkg::clip_t predict_clip(sbc3_pkg::seg_t s);
		longint p0 [3];
		longint p1 [3];
		longint a, b;
		longint unsigned t0, t1, t;
		sbc3_pkg::clip_t r;
		p0[0] = s.start_x; p0[1] = s.start_y; p0[2] = s.start_z;
		p1[0] = s.end_x;   p1[1] = s.end_y;   p1[2] = s.end_z;
		t0 = 0;
		t1 = T_ONE;
		for (int k = 0; k < 3; k++) begin
			a = p0[k];
			b = p1[k];
			// entry parameter
			if (a < box_lo[k]) begin
				if (b >= box_lo[k]) begin
					t = face_ratio(box_lo[k] - a, b - a);
					if (t > t0) t0 = t;
				end else
					t0 = T_ONE;
			end else if (a > box_hi[k]) begin
				if (b <= box_hi[k]) begin
					t = face_ratio(box_hi[k] - a, b - a);
					if (t > t0) t0 = t;
				end else
					t0 = T_ONE;
			end
			// exit parameter
			if (b < box_lo[k]) begin
				if (a >= box_lo[k]) begin
					t = face_ratio(box_lo[k] - a, b - a);
					if (t < t1) t1 = t;
				end else
					t1 = 0;
			end else if (b > box_hi[k]) begin
				if (a <= box_hi[k]) begin
					t = face_ratio(box_hi[k] - a, b - a);
					if (t < t1) t1 = t;
				end else
					t1 = 0;
			end
		end
		if (t0 > t1) begin
			r.hit = 1'b0;
			r.clip_start_x = s.start_x; r.clip_start_y = s.start_y;
			r.clip_start_z = s.start_z;
			r.clip_end_x = s.end_x; r.clip_end_y = s.end_y; r.clip_end_z = s.end_z;
		end else begin
			r.hit = 1'b1;
			r.clip_start_x = interp(p0[0], p1[0], t0);
			r.clip_start_y = interp(p0[1], p1[1], t0);
			r.clip_start_z = interp(p0[2], p1[2], t0);
			r.clip_end_x = interp(p0[0], p1[0], t1);
			r.clip_end_y = interp(p0[1], p1[1], t1);
			r.clip_end_z = interp(p0[2], p1[2], t1);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- helpers
	function automatic sbc3_pkg::coord_t fx(int v);
		return sbc3_pkg::coord_t'(longint'(v) * 65536);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic write_box(sbc3_pkg::reg_idx_t idx, sbc3_pkg::coord_t v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sbc3_pkg::ADDR_W'(idx) << 2;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= sbc3_pkg::REG_MIN_Z)
			box_lo[idx] = v;
		else
			box_hi[idx - sbc3_pkg::REG_MAX_X] = v;
	endtask

	task automatic set_box(sbc3_pkg::coord_t lx, sbc3_pkg::coord_t ly, sbc3_pkg::coord_t lz,
			sbc3_pkg::coord_t hx, sbc3_pkg::coord_t hy, sbc3_pkg::coord_t hz);
		write_box(sbc3_pkg::REG_MIN_X, lx);
		write_box(sbc3_pkg::REG_MIN_Y, ly);
		write_box(sbc3_pkg::REG_MIN_Z, lz);
		write_box(sbc3_pkg::REG_MAX_X, hx);
		write_box(sbc3_pkg::REG_MAX_Y, hy);
		write_box(sbc3_pkg::REG_MAX_Z, hz);
	endtask

	// one segment transaction; valid stays high into the next call
	task automatic send_segment(sbc3_pkg::seg_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			seg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.data  <= s;
		do @(posedge clk); while (!seg_ch.ready);
		clip_expect.insert(clip_expect.size(), predict_clip(s));
		@(negedge clk);
	endtask

	task automatic send_coords(sbc3_pkg::coord_t sx, sbc3_pkg::coord_t sy,
			sbc3_pkg::coord_t sz, sbc3_pkg::coord_t ex, sbc3_pkg::coord_t ey,
			sbc3_pkg::coord_t ez);
		sbc3_pkg::seg_t s;
		s = '{sx, sy, sz, ex, ey, ez};
		send_segment(s);
	endtask

	// drop valid, let the pipe empty, then give it the latency to settle
	task automatic drain();
		seg_ch.valid <= 1'b0;
		while (clip_expect.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic sbc3_pkg::coord_t rand_coord(int ax);
		longint lo, hi, span, v;
		longint unsigned rnd;
		int r;
		lo = (box_lo[ax] < box_hi[ax]) ? box_lo[ax] : box_hi[ax];
		hi = (box_lo[ax] < box_hi[ax]) ? box_hi[ax] : box_lo[ax];
		span = hi - lo + 1;
		r = $urandom_range(0, 99);
		rnd = {$urandom, $urandom};
		if (r < 15)
			return sbc3_pkg::coord_t'($urandom);
		if (r < 30) begin
			case ($urandom_range(0, 3))
				0: v = lo;
				1: v = hi;
				2: v = lo - 1;
				default: v = hi + 1;
			endcase
		end else
			v = lo - span / 2 + longint'(rnd % longint'(2 * span));
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		return sbc3_pkg::coord_t'(v);
	endfunction

	function automatic sbc3_pkg::seg_t rand_segment();
		sbc3_pkg::seg_t s;
		s.start_x = rand_coord(0);
		s.start_y = rand_coord(1);
		s.start_z = rand_coord(2);
		if ($urandom_range(0, 9) == 0) begin
			s.end_x = s.start_x; s.end_y = s.start_y; s.end_z = s.start_z;
		end else begin
			s.end_x = rand_coord(0);
			s.end_y = rand_coord(1);
			s.end_z = rand_coord(2);
		end
		return s;
	endfunction

	// ---------------------------------------------------------------- checker
	task automatic check_coord(string name, sbc3_pkg::coord_t e, sbc3_pkg::coord_t g);
		if (g !== e) begin
			$error("%s: expected %0d, got %0d", name, e, g);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sbc3_pkg::clip_t e, g;
		if (arst_n && clip_ch.valid && clip_ch.ready) begin
			g = clip_ch.data;
			if (clip_expect.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = clip_expect.pop_front();
				if (g.hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, g.hit);
					errors++;
				end
				check_coord("clip_start_x", e.clip_start_x, g.clip_start_x);
				check_coord("clip_start_y", e.clip_start_y, g.clip_start_y);
				check_coord("clip_start_z", e.clip_start_z, g.clip_start_z);
				check_coord("clip_end_x", e.clip_end_x, g.clip_end_x);
				check_coord("clip_end_y", e.clip_end_y, g.clip_end_y);
				check_coord("clip_end_z", e.clip_end_z, g.clip_end_z);
			end
		end
	end

	// output back-pressure: short stalls mostly, a few long ones
	always @(negedge clk) begin
		if (steady) begin
			clip_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			clip_ch.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:69]:  clip_ch.ready <= 1'b1;
				[70:96]: begin
					stall_left = $urandom_range(0, 3);
					clip_ch.ready <= 1'b0;
				end
				default: begin
					stall_left = $urandom_range(15, 50);
					clip_ch.ready <= 1'b0;
				end
			endcase
		end
	end

	// watchdog on cycles without progress
	always @(posedge clk) begin
		if ((seg_ch.valid && seg_ch.ready) || (clip_ch.valid && clip_ch.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// box cleared by reset: segments through it collapse onto the origin, one misses
	task automatic test_reset_box();
		send_coords(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1));
		send_coords(0, 0, 0, 0, 0, 0);
		send_coords(fx(1), 0, 0, fx(2), 0, 0);
		drain();
	endtask

	// small box, one case per face test path
	task automatic test_face_cases();
		set_box(fx(-10), fx(-10), fx(-10), fx(10), fx(10), fx(10));
		send_coords(fx(-1), fx(2), fx(3), fx(4), fx(-5), fx(6));      // fully inside
		send_coords(fx(-20), 0, 0, fx(20), 0, 0);                     // through on x
		send_coords(fx(20), fx(1), 0, fx(-20), fx(-1), 0);            // reverse direction
		send_coords(fx(15), 0, 0, fx(30), 0, 0);                      // both beyond max
		send_coords(0, 0, fx(-15), 0, 0, fx(-30));                    // both below min
		send_coords(fx(-30), fx(-30), fx(-30), fx(30), fx(30), fx(30)); // diagonal
		send_coords(fx(-30), fx(30), 0, fx(30), fx(-30), 0);          // crosses the center diagonally
		send_coords(fx(3), fx(3), fx(3), fx(3), fx(3), fx(3));        // point inside
		send_coords(fx(3), fx(12), fx(3), fx(3), fx(12), fx(3));      // point outside
		send_coords(fx(10), fx(-10), fx(10), fx(10), fx(-10), fx(10)); // point on faces
		send_coords(fx(-11), 0, 0, fx(-10), 0, 0);                    // touches min face
		send_coords(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_coords(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
			32'haaaa_aaaa, 32'h5555_5555, 32'hffff_fffe);
		drain();
	endtask

	// extreme registers, extreme coordinates, then two inverted boxes
	task automatic test_extremes();
		set_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_coords(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_coords(32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, -1, 32'sh7fffffff);
		drain();
		set_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_coords(0, 0, 0, fx(1), fx(1), fx(1));
		send_coords(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		drain();
		set_box(fx(5), fx(-5), fx(-5), fx(-5), fx(5), fx(5));
		send_coords(fx(-8), 0, 0, fx(8), 0, 0);
		send_coords(0, 0, 0, 0, 0, 0);
		drain();
	endtask

	// random boxes of several sizes, random segments around them
	task automatic test_random_segments();
		longint a, b, w;
		sbc3_pkg::coord_t lo [3];
		sbc3_pkg::coord_t hi [3];
		for (int phase = 0; phase < 8; phase++) begin
			for (int k = 0; k < 3; k++) begin
				case (phase % 4)
					0: w = $urandom_range(0, 32'h0010_0000);
					1: w = $urandom_range(0, 32'h4000_0000);
					2: w = $urandom_range(0, 100);
					default: w = longint'($urandom) * 2;
				endcase
				a = longint'(sbc3_pkg::coord_t'($urandom)) - w / 2;
				if (a < -64'sd2147483648) a = -64'sd2147483648;
				b = a + w;
				if (b > 64'sd2147483647) b = 64'sd2147483647;
				if (phase == 7 && k == 0) begin
					lo[k] = sbc3_pkg::coord_t'(b); hi[k] = sbc3_pkg::coord_t'(a);
				end else begin
					lo[k] = sbc3_pkg::coord_t'(a); hi[k] = sbc3_pkg::coord_t'(b);
				end
			end
			set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
			steady = (phase == 3);
			for (int i = 0; i < 100; i++)
				send_segment(rand_segment());
			steady = 1'b0;
			drain();
		end
	endtask

	// ---------------------------------------------------------------- main
	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		seg_ch.valid  = 1'b0;
		seg_ch.data   = '0;
		clip_ch.ready = 1'b0;
		errors        = 0;
		steady        = 1'b0;
		stall_left    = 0;
		quiet_cycles  = 0;
		for (int k = 0; k < 3; k++) begin
			box_lo[k] = 0;
			box_hi[k] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_box();
		test_face_cases();
		test_extremes();
		test_random_segments();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule : testbench

`default_nettype wire
